// File: hw/rtl/erkf_pkg.sv
package erkf_pkg;

    localparam int WindowMaxDefault = 16;
    localparam int PulseW  = 15;
    localparam int DistW   = 18;
    localparam int EstW    = 17;
    localparam int VarW    = 24;
    localparam int PpredW  = 25;
    localparam int GainW   = 17;

    localparam logic [DistW-1:0] MinDist = 18'd512;
    localparam logic [DistW-1:0] MaxDist = 18'd102400;
    localparam logic [VarW-1:0]  Unity   = 24'd65536;

    localparam logic [2:0] RegSpeed = 3'd0;
    localparam logic [2:0] RegQ     = 3'd1;
    localparam logic [2:0] RegR     = 3'd2;
    localparam logic [2:0] RegLen   = 3'd3;
    localparam logic [2:0] RegLimit = 3'd4;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatTimeout = 2'd1;
    localparam logic [1:0] StatRange   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_CHECK, S_SUM, S_TEST, S_FILL,
        S_PRED, S_DIV, S_EST, S_VAR, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic sum_clr;
        logic sum_step;
        logic test;
        logic fill_step;
        logic restart;
        logic push;
        logic pred;
        logic div_step;
        logic est;
        logic var_upd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic       timeout;
        logic       range_bad;
        logic       initialized;
        logic       sum_done;
        logic       outlier;
        logic       third_reject;
        logic       fill_done;
        logic       div_done;
    } t_stat;

endpackage

// File: hw/rtl/erkf_ctrl.sv
module erkf_ctrl
    import erkf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_DIST;
            S_DIST:  n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.timeout || i_stat.range_bad) n_state = S_OUT;
                else if (!i_stat.initialized)            n_state = S_FILL;
                else                                     n_state = S_SUM;
            end
            S_SUM:   if (i_stat.sum_done) n_state = S_TEST;
            S_TEST: begin
                if (!i_stat.outlier)          n_state = S_PRED;
                else if (i_stat.third_reject) n_state = S_FILL;
                else                          n_state = S_OUT;
            end
            S_FILL:  if (i_stat.fill_done) n_state = S_OUT;
            S_PRED:  n_state = S_DIV;
            S_DIV:   if (i_stat.div_done) n_state = S_EST;
            S_EST:   n_state = S_VAR;
            S_VAR:   n_state = S_OUT;
            S_OUT:   if (!i_out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIST:  o_cmd.conv = 1'b1;
            S_CHECK: o_cmd.sum_clr = 1'b1;
            S_SUM:   o_cmd.sum_step = 1'b1;
            S_TEST: begin
                o_cmd.test = 1'b1;
                o_cmd.push = !i_stat.outlier;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.restart = i_stat.fill_done;
            end
            S_PRED:  o_cmd.pred = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_EST:   o_cmd.est = 1'b1;
            S_VAR:   o_cmd.var_upd = 1'b1;
            S_OUT:   o_cmd.out_load = !i_out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: hw/rtl/erkf_datapath.sv
module erkf_datapath
    import erkf_pkg::*;
#(
    parameter int WINDOW_MAX = WindowMaxDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [PulseW-1:0] i_pulse_us,
    input  logic [15:0]       i_speed,
    input  logic [VarW-1:0]   i_q,
    input  logic [VarW-1:0]   i_r,
    input  logic [4:0]        i_len_cfg,
    input  logic [17:0]       i_limit,
    output logic [EstW-1:0]   o_filtered_distance,
    output logic              o_has_estimate,
    output logic [1:0]        o_status
);

    localparam int IdxW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LenW = $clog2(WINDOW_MAX + 1);
    localparam int SumW = DistW + LenW;
    localparam int ScW  = DistW + LenW + 1;

    logic [DistW-1:0] r_mem [WINDOW_MAX];
    logic [DistW-1:0] r_rd;

    logic [PulseW-1:0] r_pulse;
    logic [DistW-1:0]  r_d;
    logic [EstW-1:0]   r_est;
    logic [VarW-1:0]   r_var;
    logic              r_init;
    logic [IdxW-1:0]   r_oldest;
    logic [1:0]        r_rej;
    logic [LenW-1:0]   r_len;
    logic [LenW:0]     r_cnt;
    logic              r_rd_ok;
    logic [SumW-1:0]   r_sum;
    logic [PpredW-1:0] r_ppred;
    logic [PpredW:0]   r_den;
    logic [PpredW+1:0] r_rem;
    logic [GainW-1:0]  r_k;
    logic [4:0]        r_bit;
    logic [EstW-1:0]   r_resid;
    logic              r_neg;

    logic [4:0] len_c;
    always_comb begin
        len_c = (i_len_cfg == 5'd0) ? 5'd1 : i_len_cfg;
        if (32'(len_c) > WINDOW_MAX) len_c = 5'(WINDOW_MAX);
    end

    logic [IdxW-1:0] rd_idx;
    assign rd_idx = r_cnt[IdxW-1:0];

    // A pointer left past a shrunken window restarts at slot zero.
    logic [IdxW-1:0] oldest_eff;
    assign oldest_eff = (32'(r_oldest) >= 32'(r_len)) ? '0 : r_oldest;

    // Window reads: one slot per cycle, data registered.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_idx];
        if (i_cmd.fill_step && r_cnt < (LenW+1)'(r_len))
            r_mem[rd_idx] <= r_d;
        else if (i_cmd.push)
            r_mem[oldest_eff] <= r_d;
    end

    logic [ScW-1:0] scaled, lim_sc, dev;
    assign scaled = ScW'(r_d) * ScW'(r_len);
    assign lim_sc = ScW'(i_limit) * ScW'(r_len);
    assign dev = (scaled >= ScW'(r_sum)) ? scaled - ScW'(r_sum) : ScW'(r_sum) - scaled;

    logic [1:0] rej_n;
    assign rej_n = r_rej + 2'd1;

    assign o_stat.timeout      = (r_pulse == '0);
    assign o_stat.range_bad    = (r_d < MinDist) || (r_d > MaxDist);
    assign o_stat.initialized  = r_init;
    assign o_stat.sum_done     = (r_cnt == (LenW+1)'(r_len)) && !r_rd_ok;
    assign o_stat.outlier      = dev > lim_sc;
    assign o_stat.third_reject = (rej_n == 2'd3);
    assign o_stat.fill_done    = (r_cnt == (LenW+1)'(r_len));
    assign o_stat.div_done     = (r_bit == 5'd0);

    logic [PpredW+1:0] rem_sh;
    assign rem_sh = {r_rem[PpredW:0], 1'b0};

    logic [GainW+EstW-1:0] prod_e;
    logic [GainW+PpredW-1:0] prod_v;
    logic [EstW-1:0] delta;
    logic [VarW+GainW:0] p_full;
    assign prod_e = (GainW+EstW)'(r_k) * (GainW+EstW)'(r_resid);
    assign delta  = EstW'((prod_e + 34'd32768) >> 16);
    assign prod_v = (GainW+PpredW)'(GainW'(Unity) - r_k) * (GainW+PpredW)'(r_ppred);
    assign p_full = (VarW+GainW+1)'((prod_v + 42'd32768) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
            r_var <= '0;
            r_init <= 1'b0;
            r_oldest <= '0;
            r_rej <= '0;
            o_filtered_distance <= '0;
            o_has_estimate <= 1'b0;
            o_status <= StatOk;
        end else begin
            if (i_cmd.load) begin
                r_pulse <= i_pulse_us;
                r_len <= LenW'(len_c);
                r_cnt <= '0;
            end
            if (i_cmd.conv)
                r_d <= DistW'((33'(r_pulse) * 33'(i_speed)) >> 13);
            if (i_cmd.sum_clr) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_rd_ok <= 1'b0;
            end
            if (i_cmd.sum_step) begin
                if (r_rd_ok) r_sum <= r_sum + SumW'(r_rd);
                r_rd_ok <= (r_cnt < (LenW+1)'(r_len));
                if (r_cnt < (LenW+1)'(r_len)) r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.test) begin
                r_cnt <= '0;
                if (o_stat.outlier) r_rej <= rej_n;
                else r_rej <= '0;
            end
            if (i_cmd.push) begin
                if (32'(oldest_eff) + 1 >= 32'(r_len))
                    r_oldest <= '0;
                else
                    r_oldest <= oldest_eff + 1'b1;
            end
            if (i_cmd.fill_step && r_cnt < (LenW+1)'(r_len)) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.restart) begin
                r_est <= EstW'(r_d);
                r_var <= Unity;
                r_init <= 1'b1;
                r_oldest <= '0;
                r_rej <= '0;
            end
            if (i_cmd.pred) begin
                r_ppred <= PpredW'(r_var) + PpredW'(i_q);
                r_den <= (PpredW+1)'(r_var) + (PpredW+1)'(i_q) + (PpredW+1)'(i_r);
                r_rem <= (PpredW+2)'(PpredW'(r_var) + PpredW'(i_q));
                r_k <= '0;
                r_bit <= 5'd17;
                r_neg <= (r_d < 18'(r_est));
                r_resid <= (r_d >= 18'(r_est)) ? EstW'(r_d - 18'(r_est)) : EstW'(18'(r_est) - r_d);
            end
            // Restoring division, one gain bit per cycle. The first step yields
            // the integer bit, which is set only when the noise R is zero.
            if (i_cmd.div_step && r_bit != 5'd0) begin
                if (r_bit == 5'd17 && r_den == '0) begin
                    r_bit <= 5'd0;
                end else begin
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd17) begin
                        if (r_rem >= (PpredW+2)'(r_den)) begin
                            r_rem <= r_rem - (PpredW+2)'(r_den);
                            r_k <= GainW'(1);
                        end
                    end else if (rem_sh >= (PpredW+2)'(r_den)) begin
                        r_rem <= rem_sh - (PpredW+2)'(r_den);
                        r_k <= {r_k[GainW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_k <= {r_k[GainW-2:0], 1'b0};
                    end
                end
            end
            if (i_cmd.est) r_est <= r_neg ? r_est - delta : r_est + delta;
            if (i_cmd.var_upd)
                r_var <= (p_full > (VarW+GainW+1)'({VarW{1'b1}})) ? {VarW{1'b1}} : VarW'(p_full);
            if (i_cmd.out_load) begin
                o_filtered_distance <= r_init ? r_est : '0;
                o_has_estimate <= r_init;
                o_status <= o_stat.timeout ? StatTimeout :
                            (o_stat.range_bad ? StatRange : StatOk);
            end
        end
    end

endmodule

// File: hw/rtl/echo_range_kalman_filter_unit.sv
// Request paths: timeout or out-of-range requests go straight to the output, the first
// reading fills the window, an outlier is ignored, the third outlier in a row restarts
// the filter from a window fill, and any other reading takes a Kalman update.
// One request is in work at a time; the next can be taken in the cycle after the result
// is loaded, later while a result waits. The window sum and the 17-step gain divider
// are the iterative steps of an update. Synchronous active-low reset clears the estimate, variance,
// window pointer, rejection count and registers to their defaults; slots are not cleared.
module echo_range_kalman_filter_unit
    import erkf_pkg::*;
#(
    parameter int WINDOW_MAX = WindowMaxDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [PulseW-1:0] i_pulse_us,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [EstW-1:0]   o_filtered_distance,
    output logic              o_has_estimate,
    output logic [1:0]        o_status,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0]     r_speed;
    logic [VarW-1:0] r_q, r_r;
    logic [4:0]      r_len;
    logic [17:0]     r_limit;
    logic [2:0]      reg_idx;
    t_cmd            cmd;
    t_stat           stat;
    logic            r_out_valid;

    assign pready = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= 16'd36010;
            r_q <= 24'd655;
            r_r <= 24'd65536;
            r_len <= 5'd5;
            r_limit <= 18'd5120;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                RegSpeed: r_speed <= pwdata[15:0];
                RegQ:     r_q <= pwdata[23:0];
                RegR:     r_r <= pwdata[23:0];
                RegLen:   r_len <= pwdata[4:0];
                RegLimit: r_limit <= pwdata[17:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            RegSpeed: prdata = {16'd0, r_speed};
            RegQ:     prdata = {8'd0, r_q};
            RegR:     prdata = {8'd0, r_r};
            RegLen:   prdata = {27'd0, r_len};
            RegLimit: prdata = {14'd0, r_limit};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (cmd.out_load) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end
    assign o_out_valid = r_out_valid;

    erkf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_out_busy(r_out_valid && !i_out_ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    erkf_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_pulse_us(i_pulse_us), .i_speed(r_speed), .i_q(r_q), .i_r(r_r),
        .i_len_cfg(r_len), .i_limit(r_limit),
        .o_filtered_distance(o_filtered_distance),
        .o_has_estimate(o_has_estimate), .o_status(o_status)
    );

endmodule

// File: hw/rtl/erkf_checker.sv
module erkf_checker
    import erkf_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [EstW-1:0] o_filtered_distance,
    input logic            o_has_estimate,
    input logic [1:0]      o_status
);

    a_no_est_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_estimate |-> o_filtered_distance == '0)
        else $error("distance nonzero without estimate");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 2'd3)
        else $error("bad status");

    a_est_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_filtered_distance <= 17'd102400)
        else $error("estimate out of range");

    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

endmodule

bind echo_range_kalman_filter_unit erkf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_filtered_distance(o_filtered_distance), .o_has_estimate(o_has_estimate),
    .o_status(o_status)
);
